// ----- design/pal_pkg.sv -----
// Shared definitions for the positional array list: operation and status codes,
// cell commands, controller states and default sizes.
// No dependencies.
package pal_pkg;

	localparam int DEFAULT_DEPTH      = 64;
	localparam int DEFAULT_DATA_WIDTH = 32;

	// Port field widths.
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// Width of the positions carried to the cells; covers the largest supported depth.
	localparam int IDX_W = 11;

	typedef enum logic [1:0] {
		OP_TRAVERSE = 2'd0,
		OP_SEARCH   = 2'd1,
		OP_INSERT   = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_REJECT   = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  tail;
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} ctl_state_t;

endpackage

// ----- design/pal_cell.sv -----
// One storage cell of the list chain: holds a single entry and takes a new one
// from its left or right neighbour, the head cell or the input word.
// Depends on pal_pkg.
module pal_cell #(
	parameter int DATA_WIDTH = pal_pkg::DEFAULT_DATA_WIDTH,
	parameter int IDX        = 0
) (
	input  logic                   clk,
	input  pal_pkg::cell_cmd_t     cmd,
	input  logic [DATA_WIDTH-1:0]  value,
	input  logic [DATA_WIDTH-1:0]  left,
	input  logic [DATA_WIDTH-1:0]  right,
	input  logic [DATA_WIDTH-1:0]  head,
	output logic [DATA_WIDTH-1:0]  q
);

	localparam logic [pal_pkg::IDX_W-1:0] IDX_C = pal_pkg::IDX_W'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_nxt;

	always_comb begin
		entry_nxt = entry_q;
		unique case (cmd.op)
			pal_pkg::CELL_INSERT: begin
				priority if (IDX_C > cmd.pos) begin
					entry_nxt = left;
				end else if (IDX_C == cmd.pos) begin
					entry_nxt = value;
				end else begin
					entry_nxt = entry_q;
				end
			end
			pal_pkg::CELL_DELETE: begin
				if (IDX_C >= cmd.pos) begin
					entry_nxt = right;
				end
			end
			pal_pkg::CELL_ROTATE: begin
				// The cell at the tail of the list takes the head so that the list
				// comes back to its place after one full turn.
				priority if (IDX_C < cmd.tail) begin
					entry_nxt = right;
				end else if (IDX_C == cmd.tail) begin
					entry_nxt = head;
				end else begin
					entry_nxt = entry_q;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign q = entry_q;

endmodule

// ----- design/positional_array_list.sv -----
// Top level of the positional array list: controller, element count and the
// chain of pal_cell storage cells. Depends on pal_pkg and pal_cell.
//
// Insert and delete: the word is taken with start high and busy low, and its
// single result appears on the next cycle with done high; busy stays low, so a
// new word may follow at once. Traverse and search of a list with N entries
// keep busy high while the cell chain turns one place a cycle past the head
// cell, which is emitted on traverse (one result each cycle, last on the final
// one) and compared with the key on search (one result after the full turn,
// which also restores the list). On an empty list both give a single result
// in the cycle after the start. Results are shown for exactly one cycle and
// cannot be held off. No clearing pass is needed after reset.
module positional_array_list #(
	parameter int DEPTH      = pal_pkg::DEFAULT_DEPTH,
	parameter int DATA_WIDTH = pal_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          operation,
	input  logic signed [pal_pkg::VALUE_W-1:0]  value,
	input  logic [pal_pkg::POS_W-1:0]           position,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [pal_pkg::INDEX_W-1:0]         index,
	output logic signed [pal_pkg::VALUE_W-1:0]  data,
	output logic [pal_pkg::COUNT_W-1:0]         count,
	output logic                                last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

	pal_pkg::ctl_state_t state_q, state_nxt;

	logic [CW-1:0]         count_q;
	logic [IW-1:0]         scan_q;
	logic                  search_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic                  found_q;
	logic [IW-1:0]         found_idx_q;

	logic                            done_q;
	logic [1:0]                      status_q;
	logic [pal_pkg::INDEX_W-1:0]     index_q;
	logic [pal_pkg::VALUE_W-1:0]     data_q;
	logic [pal_pkg::COUNT_W-1:0]     count_out_q;
	logic                            last_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] value_dw;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	logic                  ins_ok;
	logic                  del_ok;
	logic                  list_empty;
	logic                  scan_last;
	logic                  hit;
	logic [CW-1:0]         tail;
	logic [DATA_WIDTH-1:0] head;

	pal_pkg::cell_cmd_t    cmd;
	logic                  res_fire;
	pal_pkg::status_t      res_status;
	logic [IW-1:0]         res_index;
	logic [DATA_WIDTH-1:0] res_data;
	logic [CW-1:0]         res_count;
	logic                  res_last;

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];

	// Fit the signed input word to the stored width.
	generate
		if (DATA_WIDTH <= pal_pkg::VALUE_W) begin : g_val_trunc
			assign value_dw = value[DATA_WIDTH-1:0];
		end else begin : g_val_ext
			assign value_dw = {{(DATA_WIDTH - pal_pkg::VALUE_W){value[pal_pkg::VALUE_W-1]}},
				value};
		end
	endgenerate

	assign busy       = (state_q == pal_pkg::S_SCAN);
	assign accept     = start && !busy;
	assign pos_w      = PW'(position);
	assign cnt_w      = PW'(count_q);
	assign list_empty = (count_q == '0);
	assign ins_ok     = (count_q != CW'(DEPTH)) && (pos_w <= cnt_w);
	assign del_ok     = !list_empty && (pos_w < cnt_w);
	assign tail       = count_q - 1'b1;
	assign scan_last  = (CW'(scan_q) == tail);
	assign head       = cell_q[0];
	assign hit        = (head == key_q);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pal_pkg::S_IDLE: begin
				if (accept && !list_empty &&
				    (operation == pal_pkg::OP_TRAVERSE || operation == pal_pkg::OP_SEARCH)) begin
					state_nxt = pal_pkg::S_SCAN;
				end
			end
			pal_pkg::S_SCAN: begin
				if (scan_last) begin
					state_nxt = pal_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pal_pkg::S_IDLE;
			end
		endcase
	end

	// Cell command and the next result word.
	always_comb begin
		cmd.op     = pal_pkg::CELL_HOLD;
		cmd.pos    = pal_pkg::IDX_W'(position);
		cmd.tail   = pal_pkg::IDX_W'(tail);
		res_fire   = 1'b0;
		res_status = pal_pkg::STAT_DONE;
		res_index  = '0;
		res_data   = '0;
		res_count  = count_q;
		res_last   = 1'b1;
		unique case (state_q)
			pal_pkg::S_IDLE: begin
				if (accept) begin
					unique case (pal_pkg::op_t'(operation))
						pal_pkg::OP_TRAVERSE: begin
							res_fire   = list_empty;
							res_status = pal_pkg::STAT_EMPTY;
						end
						pal_pkg::OP_SEARCH: begin
							res_fire   = list_empty;
							res_status = pal_pkg::STAT_NOTFOUND;
						end
						pal_pkg::OP_INSERT: begin
							res_fire = 1'b1;
							if (ins_ok) begin
								cmd.op    = pal_pkg::CELL_INSERT;
								res_count = count_q + 1'b1;
							end else begin
								res_status = pal_pkg::STAT_REJECT;
							end
						end
						pal_pkg::OP_DELETE: begin
							res_fire = 1'b1;
							if (del_ok) begin
								cmd.op    = pal_pkg::CELL_DELETE;
								res_count = count_q - 1'b1;
							end else begin
								res_status = pal_pkg::STAT_REJECT;
							end
						end
						default: begin
							res_fire = 1'b0;
						end
					endcase
				end
			end
			pal_pkg::S_SCAN: begin
				cmd.op   = pal_pkg::CELL_ROTATE;
				res_last = scan_last;
				if (search_q) begin
					res_fire = scan_last;
					priority if (found_q) begin
						res_index = found_idx_q;
					end else if (hit) begin
						res_index = scan_q;
					end else begin
						res_status = pal_pkg::STAT_NOTFOUND;
					end
				end else begin
					res_fire  = 1'b1;
					res_index = scan_q;
					res_data  = head;
				end
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pal_pkg::S_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			search_q <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_fire;
			if (cmd.op == pal_pkg::CELL_INSERT || cmd.op == pal_pkg::CELL_DELETE) begin
				count_q <= res_count;
			end
			if (state_q == pal_pkg::S_IDLE) begin
				scan_q   <= '0;
				found_q  <= 1'b0;
				search_q <= (operation == pal_pkg::OP_SEARCH);
			end else begin
				scan_q <= scan_q + 1'b1;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Result word and search bookkeeping carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value_dw;
		end
		if (busy && hit && !found_q) begin
			found_idx_q <= scan_q;
		end
		status_q    <= res_status;
		index_q     <= pal_pkg::INDEX_W'(res_index);
		data_q      <= pal_pkg::VALUE_W'(res_data);
		count_out_q <= pal_pkg::COUNT_W'(res_count);
		last_q      <= res_last;
	end

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_d;
			logic [DATA_WIDTH-1:0] right_d;
			if (g == 0) begin : g_first
				assign left_d = value_dw;
			end else begin : g_mid_l
				assign left_d = cell_q[g-1];
			end
			if (g == DEPTH - 1) begin : g_final
				assign right_d = cell_q[g];
			end else begin : g_mid_r
				assign right_d = cell_q[g+1];
			end
			pal_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.IDX       (g)
			) u_cell (
				.clk  (clk),
				.cmd  (cmd),
				.value(value_dw),
				.left (left_d),
				.right(right_d),
				.head (head),
				.q    (cell_q[g])
			);
		end
	endgenerate

	assign done   = done_q;
	assign status = status_q;
	assign index  = index_q;
	assign data   = data_q;
	assign count  = count_out_q;
	assign last   = last_q;

endmodule

// ----- design/pal_checker.sv -----
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg and positional_array_list.
module pal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  operation,
	input logic [31:0] value,
	input logic [6:0]  position,
	input logic        done,
	input logic [1:0]  status,
	input logic [5:0]  index,
	input logic [31:0] data,
	input logic [6:0]  count,
	input logic        last
);

	// The final word of any operation leaves the block free for the next one.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("busy still high with the final result word");

	// A traverse word that is not the last comes while the scan runs, and the next follows.
	a_traverse_runs: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy ##1 done)
		else $error("traverse result words are not contiguous");

	// Insert and delete answer with one final word in the next cycle.
	a_edit_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy &&
		(operation == pal_pkg::OP_INSERT || operation == pal_pkg::OP_DELETE)
		|=> done && last)
		else $error("insert or delete gave no result word");

	// An empty traverse reports an empty list with no data.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == pal_pkg::STAT_EMPTY |-> count == '0 && data == '0 && last)
		else $error("malformed empty-list result word");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);
